// ----- hdl/hh_pkg.sv -----
// hopscotch hash table package: table size, state codes, status codes and mode codes
// no dependencies
package hh_pkg;

  localparam int BUCKETS = 256;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_ERASE  = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_NEW        = 3'd0,
    ST_ASSIGNED   = 3'd1,
    ST_FOUND      = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_ERASED     = 3'd4,
    ST_CLEARED    = 3'd5,
    ST_NEED_TABLE = 3'd6,
    ST_NEED_NH    = 3'd7
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN,
    S_HOLE_RD,
    S_HOLE,
    S_WIN_RD,
    S_WIN,
    S_MOVE_RD,
    S_MOVE,
    S_CLEAR,
    S_DONE
  } state_t;

  localparam int NH_WIDTH = 7;
  localparam logic [NH_WIDTH-1:0] NH_RESET = 7'd8;

endpackage

// ----- hdl/hopscotch_hash_table.sv -----
// hopscotch hash table top level: sequencer, bucket memories and valid bits
// depends on hh_pkg
// accept to result strobe: lookup checks each neighbourhood bucket in turn; erase goes
// straight to S_DONE, clear through S_CLEAR; add scans, searches for a hole, then hops
// busy high through the strobe cycle, next item taken the cycle after; no stall
// sync reset clears valid bits and count, sets nh_reg to NH_RESET; no clearing pass
module hopscotch_hash_table #(
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 mode,
  input  logic [KEY_WIDTH-1:0]       key,
  input  logic [31:0]                key_hash,
  input  logic [VALUE_WIDTH-1:0]     value,
  input  logic [7:0]                 bucket_index,
  input  logic                       cfg_we,
  input  logic [hh_pkg::NH_WIDTH-1:0] cfg_wdata,
  output logic                       result_valid,
  output logic [2:0]                 status,
  output logic [7:0]                 bucket,
  output logic [VALUE_WIDTH-1:0]     found_value,
  output logic [8:0]                 used_count
);
  import hh_pkg::*;

  localparam int AW = $clog2(BUCKETS);
  localparam int CW = AW + 1;

  // memories
  logic [31:0]            mem_hash [BUCKETS];
  logic [KEY_WIDTH-1:0]   mem_key  [BUCKETS];
  logic [VALUE_WIDTH-1:0] mem_val  [BUCKETS];
  logic [BUCKETS-1:0]     vbits;

  logic [AW-1:0]          rd_addr;
  logic [31:0]            rd_hash;
  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic                   rd_valid;

  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [31:0]            wr_hash;
  logic [KEY_WIDTH-1:0]   wr_key;
  logic [VALUE_WIDTH-1:0] wr_val;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_hash[wr_addr] <= wr_hash;
      mem_key[wr_addr]  <= wr_key;
      mem_val[wr_addr]  <= wr_val;
    end
    rd_hash  <= mem_hash[rd_addr];
    rd_key   <= mem_key[rd_addr];
    rd_val   <= mem_val[rd_addr];
    rd_valid <= vbits[rd_addr];
  end

  // registers
  state_t                 state, state_next;
  logic [NH_WIDTH-1:0]    nh_reg;
  logic [8:0]             used;
  logic [1:0]             op;
  logic [KEY_WIDTH-1:0]   k_reg;
  logic [31:0]            h_reg;
  logic [VALUE_WIDTH-1:0] v_reg;
  logic [CW-1:0]          cnt, cnt_next;
  logic [AW-1:0]          hole, hole_next;
  logic [AW-1:0]          ws, ws_next;
  logic [31:0]            sample, sample_next;
  logic                   sample_ok, sample_ok_next;
  logic [CW-1:0]          coll, coll_next;
  logic [AW-1:0]          mov, mov_next;
  logic [2:0]             st_r, st_next;
  logic [7:0]             bk_r, bk_next;
  logic [VALUE_WIDTH-1:0] fv_r, fv_next;
  logic [8:0]             used_next;
  logic                   set_en, clr_en;
  logic [AW-1:0]          set_addr, clr_addr;
  logic                   clr_all;

  // effective neighbourhood and derived values
  logic [CW-1:0] nh;
  always_comb begin
    if (nh_reg == '0) nh = CW'(1);
    else if (32'(nh_reg) > 32'(BUCKETS)) nh = CW'(BUCKETS);
    else nh = CW'(nh_reg);
  end

  logic [AW-1:0] home;
  assign home = h_reg[AW-1:0];

  logic [AW-1:0] cur;
  logic [AW-1:0] d_home_hole, d_rd_hole;
  assign d_home_hole = hole - home;
  assign d_rd_hole   = hole - rd_hash[AW-1:0];

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    hole_next      = hole;
    ws_next        = ws;
    sample_next    = sample;
    sample_ok_next = sample_ok;
    coll_next      = coll;
    mov_next       = mov;
    st_next        = st_r;
    bk_next        = bk_r;
    fv_next        = fv_r;
    used_next      = used;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_hash        = h_reg;
    wr_key         = k_reg;
    wr_val         = v_reg;
    set_en         = 1'b0;
    set_addr       = '0;
    clr_en         = 1'b0;
    clr_addr       = '0;
    clr_all        = 1'b0;
    cur            = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cnt_next = '0;
          fv_next  = '0;
          bk_next  = '0;
          unique case (mode_t'(mode))
            MODE_ADD, MODE_LOOKUP: state_next = S_SCAN_RD;
            MODE_ERASE: begin
              bk_next = bucket_index;
              if (32'(bucket_index) < 32'(BUCKETS) && vbits[AW'(bucket_index)]) begin
                clr_en    = 1'b1;
                clr_addr  = AW'(bucket_index);
                used_next = used - 9'd1;
                st_next   = ST_ERASED;
              end else begin
                st_next = ST_NOT_FOUND;
              end
              state_next = S_DONE;
            end
            default: state_next = S_CLEAR;
          endcase
        end
      end
      S_SCAN_RD: begin
        rd_addr    = home + cnt[AW-1:0];
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cur = home + cnt[AW-1:0];
        if (op == MODE_LOOKUP) begin
          if (rd_valid && rd_hash == h_reg && rd_key == k_reg) begin
            st_next = ST_FOUND; bk_next = 8'(cur); fv_next = rd_val;
            state_next = S_DONE;
          end else if (cnt + CW'(1) >= nh) begin
            st_next = ST_NOT_FOUND; state_next = S_DONE;
          end else begin
            cnt_next = cnt + CW'(1); state_next = S_SCAN_RD;
          end
        end else if (!rd_valid) begin
          wr_en = 1'b1; wr_addr = cur; set_en = 1'b1; set_addr = cur;
          used_next = used + 9'd1; st_next = ST_NEW; bk_next = 8'(cur);
          state_next = S_DONE;
        end else if (rd_hash == h_reg && rd_key == k_reg) begin
          wr_en = 1'b1; wr_addr = cur; wr_hash = rd_hash; wr_key = rd_key;
          st_next = ST_ASSIGNED; bk_next = 8'(cur); state_next = S_DONE;
        end else if (cnt + CW'(1) >= nh) begin
          cnt_next = '0; state_next = S_HOLE_RD;
        end else begin
          cnt_next = cnt + CW'(1); state_next = S_SCAN_RD;
        end
      end
      S_HOLE_RD: begin
        if (cnt >= CW'(BUCKETS) - nh) begin
          st_next = ST_NEED_TABLE; state_next = S_DONE;
        end else begin
          rd_addr = home + nh[AW-1:0] + cnt[AW-1:0];
          state_next = S_HOLE;
        end
      end
      S_HOLE: begin
        if (!rd_valid) begin
          hole_next  = home + nh[AW-1:0] + cnt[AW-1:0];
          state_next = S_WIN_RD;
        end else begin
          cnt_next = cnt + CW'(1); state_next = S_HOLE_RD;
        end
      end
      S_WIN_RD: begin
        // hole in neighbourhood: place new entry
        if (CW'(d_home_hole) < nh) begin
          wr_en = 1'b1; wr_addr = hole; set_en = 1'b1; set_addr = hole;
          used_next = used + 9'd1; st_next = ST_NEW; bk_next = 8'(hole);
          state_next = S_DONE;
        end else begin
          ws_next    = hole - AW'(nh - CW'(1));
          rd_addr    = hole - AW'(nh - CW'(1));
          cnt_next   = '0;
          coll_next  = '0;
          state_next = S_WIN;
        end
      end
      S_WIN: begin
        // rd data holds bucket ws+cnt
        if (cnt == '0) begin
          sample_next    = rd_hash;
          sample_ok_next = rd_valid;
        end
        if (cnt >= nh - CW'(1)) begin
          st_next = (coll < nh - CW'(1)) ? ST_NEED_TABLE : ST_NEED_NH;
          state_next = S_DONE;
        end else if (rd_valid && CW'(d_rd_hole) < nh) begin
          mov_next   = ws + cnt[AW-1:0];
          state_next = S_MOVE_RD;
        end else begin
          if (rd_valid && (cnt == '0 ? rd_valid : sample_ok) &&
              rd_hash == (cnt == '0 ? rd_hash : sample))
            coll_next = coll + CW'(1);
          cnt_next = cnt + CW'(1);
          rd_addr  = ws + cnt[AW-1:0] + AW'(1);
        end
      end
      S_MOVE_RD: begin
        rd_addr    = mov;
        state_next = S_MOVE;
      end
      S_MOVE: begin
        wr_en = 1'b1; wr_addr = hole;
        wr_hash = rd_hash; wr_key = rd_key; wr_val = rd_val;
        set_en = 1'b1; set_addr = hole;
        clr_en = 1'b1; clr_addr = mov;
        hole_next  = mov;
        state_next = S_WIN_RD;
      end
      S_CLEAR: begin
        clr_all = 1'b1; used_next = '0; st_next = ST_CLEARED;
        state_next = S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      nh_reg <= NH_RESET;
      used   <= '0;
      vbits  <= '0;
    end else begin
      state <= state_next;
      used  <= used_next;
      if (cfg_we) nh_reg <= cfg_wdata;
      if (clr_all) vbits <= '0;
      else begin
        if (clr_en) vbits[clr_addr] <= 1'b0;
        if (set_en) vbits[set_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op <= mode; k_reg <= key; h_reg <= key_hash; v_reg <= value;
    end
    cnt <= cnt_next; hole <= hole_next; ws <= ws_next;
    sample <= sample_next; sample_ok <= sample_ok_next;
    coll <= coll_next; mov <= mov_next;
    st_r <= st_next; bk_r <= bk_next; fv_r <= fv_next;
  end

  assign busy         = (state != S_IDLE);
  assign result_valid = (state == S_DONE);
  assign status       = st_r;
  assign bucket       = bk_r;
  assign found_value  = fv_r;
  assign used_count   = used;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    used <= 9'(BUCKETS))
    else $error("count above table size");
  a_result_one: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result held two cycles");
  a_bi_kept: assert property (@(posedge clk) disable iff (rst)
    busy && !result_valid |=> busy)
    else $error("busy dropped without result");

endmodule
